// ===== hw/rtl/msp_pkg.sv =====
// msp_pkg: shared constants and types of the matrix saddle point finder
// no dependencies; used by msp_front, msp_back and the top level
package msp_pkg;

	// default sizes, handed to the top level parameters
	localparam int unsigned MAX_ROWS_DEF    = 8;
	localparam int unsigned MAX_COLS_DEF    = 8;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// configuration port
	localparam int unsigned CFG_W     = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);
	localparam logic [CFG_W-1:0] ROW_COUNT_RST = CFG_W'(8);
	localparam logic [CFG_W-1:0] COL_COUNT_RST = CFG_W'(8);

	// result port widths
	localparam int unsigned SEQ_W = 7;
	localparam int unsigned POS_W = 3;

	// per-element tag from the load front to the back
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last;
	} ld_tag_t;

endpackage

// ===== hw/rtl/msp_fifo.sv =====
// msp_fifo: two-entry queue between the load front and the scan back
// generic payload vector; no package dependency
module msp_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hw/rtl/msp_front.sv =====
// msp_front: configuration registers and load position tracking
// tags each accepted element with its row, column and boundary flags; uses msp_pkg
module msp_front #(
	parameter int unsigned MAX_ROWS    = msp_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS    = msp_pkg::MAX_COLS_DEF,
	parameter int unsigned VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [msp_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [msp_pkg::CFG_W-1:0]      wr_data,
	input  logic                           start,
	input  logic                           q_full,
	input  logic [VALUE_WIDTH-1:0]         element_value,
	output logic                           push,
	output logic [RW-1:0]                  push_row,
	output logic [CW-1:0]                  push_col,
	output logic [VALUE_WIDTH-1:0]         push_value,
	output msp_pkg::ld_tag_t               push_tag
);

	logic [msp_pkg::CFG_W-1:0] row_count_q;
	logic [msp_pkg::CFG_W-1:0] col_count_q;
	logic [msp_pkg::CFG_W-1:0] rows_used;
	logic [msp_pkg::CFG_W-1:0] cols_used;
	logic [RW-1:0]             last_row;
	logic [CW-1:0]             last_col;
	logic [RW-1:0]             row_q;
	logic [CW-1:0]             col_q;
	logic                      row_end;
	logic                      col_end;
	logic                      cfg_hit;

	// zero counts as one, large counts saturate
	always_comb begin
		priority if (row_count_q == '0) rows_used = msp_pkg::CFG_W'(1);
		else if (row_count_q > msp_pkg::CFG_W'(MAX_ROWS)) rows_used = msp_pkg::CFG_W'(MAX_ROWS);
		else rows_used = row_count_q;
		priority if (col_count_q == '0) cols_used = msp_pkg::CFG_W'(1);
		else if (col_count_q > msp_pkg::CFG_W'(MAX_COLS)) cols_used = msp_pkg::CFG_W'(MAX_COLS);
		else cols_used = col_count_q;
	end

	assign last_row = RW'(rows_used - msp_pkg::CFG_W'(1));
	assign last_col = CW'(cols_used - msp_pkg::CFG_W'(1));
	assign row_end  = (row_q == last_row);
	assign col_end  = (col_q == last_col);
	assign cfg_hit  = wr_en && (wr_index == msp_pkg::REG_ROW_COUNT
		|| wr_index == msp_pkg::REG_COL_COUNT);

	assign push               = start && !q_full;
	assign push_row           = row_q;
	assign push_col           = col_q;
	assign push_value         = element_value;
	assign push_tag.first_row = (row_q == '0);
	assign push_tag.first_col = (col_q == '0);
	assign push_tag.last      = row_end && col_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= msp_pkg::ROW_COUNT_RST;
			col_count_q <= msp_pkg::COL_COUNT_RST;
			row_q       <= '0;
			col_q       <= '0;
		end else if (cfg_hit) begin
			// a register write restarts loading
			if (wr_index == msp_pkg::REG_ROW_COUNT) row_count_q <= wr_data;
			else col_count_q <= wr_data;
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/msp_back.sv =====
// msp_back: matrix store, running row minima and column maxima, and the scan
// drains the load queue, then scans in row-major order and issues results; uses msp_pkg
module msp_back #(
	parameter int unsigned MAX_ROWS    = msp_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS    = msp_pkg::MAX_COLS_DEF,
	parameter int unsigned VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF,
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          pop,
	input  logic [RW-1:0]                 q_row,
	input  logic [CW-1:0]                 q_col,
	input  logic [VALUE_WIDTH-1:0]        q_value,
	input  msp_pkg::ld_tag_t              q_tag,
	output logic                          strobe,
	output logic [msp_pkg::SEQ_W-1:0]     seq_number,
	output logic [msp_pkg::POS_W-1:0]     point_row,
	output logic [msp_pkg::POS_W-1:0]     point_col,
	output logic [VALUE_WIDTH-1:0]        point_value,
	output logic                          none_found,
	output logic                          last_result
);

	localparam int unsigned AW    = RW + CW;
	localparam int unsigned DEPTH = 1 << AW;
	localparam int unsigned CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);

	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] rmin_q [MAX_ROWS];
	logic [VALUE_WIDTH-1:0] cmax_q [MAX_COLS];

	logic                   scan_act_q;
	logic [RW-1:0]          scan_row_q;
	logic [CW-1:0]          scan_col_q;
	logic [RW-1:0]          end_row_q;
	logic [CW-1:0]          end_col_q;
	logic                   scan_end;
	logic                   scan_busy;

	logic [RW-1:0]          rd_row;
	logic [CW-1:0]          rd_col;
	logic [VALUE_WIDTH-1:0] rmin_rd;
	logic [VALUE_WIDTH-1:0] cmax_rd;

	logic                   valid_s1;
	logic [VALUE_WIDTH-1:0] elem_s1;
	logic [VALUE_WIDTH-1:0] rmin_s1;
	logic [VALUE_WIDTH-1:0] cmax_s1;
	logic [RW-1:0]          row_s1;
	logic [CW-1:0]          col_s1;
	logic                   end_s1;

	logic                   valid_s2;
	logic                   hit_s2;
	logic [VALUE_WIDTH-1:0] value_s2;
	logic [RW-1:0]          row_s2;
	logic [CW-1:0]          col_s2;
	logic                   end_s2;

	logic                   fin_q;
	logic [CNT_W-1:0]       count_q;
	logic                   pend_valid_q;
	logic [CNT_W-1:0]       pend_seq_q;
	logic [RW-1:0]          pend_row_q;
	logic [CW-1:0]          pend_col_q;
	logic [VALUE_WIDTH-1:0] pend_value_q;

	logic                   new_hit;
	logic                   emit_pend;
	logic                   emit_none;

	logic                   strobe_q;
	logic [msp_pkg::SEQ_W-1:0] seq_q;
	logic [msp_pkg::POS_W-1:0] row_q;
	logic [msp_pkg::POS_W-1:0] col_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   none_q;
	logic                   last_q;

	// loading stops while a scan is in flight
	assign scan_busy = scan_act_q || valid_s1 || valid_s2 || fin_q;
	assign pop       = !q_empty && !scan_busy;
	assign scan_end  = (scan_row_q == end_row_q) && (scan_col_q == end_col_q);

	// one shared read port on the row and column registers
	assign rd_row  = scan_act_q ? scan_row_q : q_row;
	assign rd_col  = scan_act_q ? scan_col_q : q_col;
	assign rmin_rd = rmin_q[rd_row];
	assign cmax_rd = cmax_q[rd_col];

	// load side: store element, update running extremes
	always_ff @(posedge clk) begin
		if (pop) begin
			mem[{q_row, q_col}] <= q_value;
			if (q_tag.first_col || $signed(q_value) < $signed(rmin_rd)) rmin_q[q_row] <= q_value;
			if (q_tag.first_row || $signed(q_value) > $signed(cmax_rd)) cmax_q[q_col] <= q_value;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			scan_row_q <= '0;
			scan_col_q <= '0;
			end_row_q  <= '0;
			end_col_q  <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			valid_s1 <= scan_act_q;
			valid_s2 <= valid_s1;
			if (pop && q_tag.last) begin
				scan_act_q <= 1'b1;
				scan_row_q <= '0;
				scan_col_q <= '0;
				end_row_q  <= q_row;
				end_col_q  <= q_col;
			end else if (scan_act_q) begin
				if (scan_end) begin
					scan_act_q <= 1'b0;
				end else if (scan_col_q == end_col_q) begin
					scan_col_q <= '0;
					scan_row_q <= scan_row_q + RW'(1);
				end else begin
					scan_col_q <= scan_col_q + CW'(1);
				end
			end
		end
	end

	// scan data path: registered reads, then compare
	always_ff @(posedge clk) begin
		elem_s1  <= mem[{scan_row_q, scan_col_q}];
		rmin_s1  <= rmin_rd;
		cmax_s1  <= cmax_rd;
		row_s1   <= scan_row_q;
		col_s1   <= scan_col_q;
		end_s1   <= scan_end;
		hit_s2   <= (elem_s1 == rmin_s1) && (elem_s1 == cmax_s1);
		value_s2 <= elem_s1;
		row_s2   <= row_s1;
		col_s2   <= col_s1;
		end_s2   <= end_s1;
	end

	// a hit is held back one slot so the final one can carry last_result
	assign new_hit   = valid_s2 && hit_s2;
	assign emit_pend = pend_valid_q && (new_hit || fin_q);
	assign emit_none = fin_q && !pend_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q        <= 1'b0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= emit_pend || emit_none;
			fin_q    <= valid_s2 && end_s2;
			if (new_hit) begin
				count_q      <= count_q + CNT_W'(1);
				pend_valid_q <= 1'b1;
			end else if (fin_q) begin
				count_q      <= '0;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_hit) begin
			pend_seq_q   <= count_q + CNT_W'(1);
			pend_row_q   <= row_s2;
			pend_col_q   <= col_s2;
			pend_value_q <= value_s2;
		end
		if (emit_pend) begin
			seq_q   <= msp_pkg::SEQ_W'(pend_seq_q);
			row_q   <= msp_pkg::POS_W'(pend_row_q);
			col_q   <= msp_pkg::POS_W'(pend_col_q);
			value_q <= pend_value_q;
			none_q  <= 1'b0;
			last_q  <= fin_q;
		end else if (emit_none) begin
			seq_q   <= '0;
			row_q   <= '0;
			col_q   <= '0;
			value_q <= '0;
			none_q  <= 1'b1;
			last_q  <= 1'b1;
		end
	end

	assign strobe      = strobe_q;
	assign seq_number  = seq_q;
	assign point_row   = row_q;
	assign point_col   = col_q;
	assign point_value = value_q;
	assign none_found  = none_q;
	assign last_result = last_q;

endmodule

// ===== hw/rtl/matrix_saddle_point_finder_top.sv =====
// matrix_saddle_point_finder_top: loads a signed matrix, reports its saddle points
// results: each point waits for the next hit or for the end of the scan before it is issued
// throughput: one element per cycle while loading and busy is low, then a scan of the whole matrix
// the load queue takes two more elements during a scan, then busy holds start off
// results are one-cycle strobes; the receiver cannot stall them
// reset: arst_n clears control state and sets both counts to 8; stores stay undefined
module matrix_saddle_point_finder_top #(
	parameter int unsigned MAX_ROWS    = msp_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS    = msp_pkg::MAX_COLS_DEF,
	parameter int unsigned VALUE_WIDTH = msp_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// element channel
	input  logic                          start,
	output logic                          busy,
	input  logic [VALUE_WIDTH-1:0]        element_value,
	// configuration write port
	input  logic                          wr_en,
	input  logic [msp_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [msp_pkg::CFG_W-1:0]     wr_data,
	// result channel
	output logic                          strobe,
	output logic [msp_pkg::SEQ_W-1:0]     seq_number,
	output logic [msp_pkg::POS_W-1:0]     point_row,
	output logic [msp_pkg::POS_W-1:0]     point_col,
	output logic [VALUE_WIDTH-1:0]        point_value,
	output logic                          none_found,
	output logic                          last_result
);

	localparam int unsigned RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned TAG_W   = $bits(msp_pkg::ld_tag_t);
	localparam int unsigned ENTRY_W = TAG_W + RW + CW + VALUE_WIDTH;

	// front to queue
	logic                   push;
	logic [RW-1:0]          push_row;
	logic [CW-1:0]          push_col;
	logic [VALUE_WIDTH-1:0] push_value;
	msp_pkg::ld_tag_t       push_tag;

	// queue to back
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	logic [ENTRY_W-1:0]     q_data;
	logic [RW-1:0]          q_row;
	logic [CW-1:0]          q_col;
	logic [VALUE_WIDTH-1:0] q_value;
	msp_pkg::ld_tag_t       q_tag;

	// a transfer is taken whenever the queue has room
	assign busy = q_full;

	// front: configuration and load position
	msp_front #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.start         (start),
		.q_full        (q_full),
		.element_value (element_value),
		.push          (push),
		.push_row      (push_row),
		.push_col      (push_col),
		.push_value    (push_value),
		.push_tag      (push_tag)
	);

	// short queue decouples loading from the scan
	msp_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_tag, push_row, push_col, push_value}),
		.pop       (pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign {q_tag, q_row, q_col, q_value} = q_data;

	// back: store, extremes, scan and result issue
	msp_back #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.pop         (pop),
		.q_row       (q_row),
		.q_col       (q_col),
		.q_value     (q_value),
		.q_tag       (q_tag),
		.strobe      (strobe),
		.seq_number  (seq_number),
		.point_row   (point_row),
		.point_col   (point_col),
		.point_value (point_value),
		.none_found  (none_found),
		.last_result (last_result)
	);

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for matrix_saddle_point_finder_top, random and directed matrices
// a scoreboard class predicts every saddle point from the accepted elements and config writes
// depends on msp_pkg and the top level RTL only
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned VW            = msp_pkg::VALUE_WIDTH_DEF;
	localparam int unsigned ROWS_MAX      = msp_pkg::MAX_ROWS_DEF;
	localparam int unsigned COLS_MAX      = msp_pkg::MAX_COLS_DEF;
	localparam int unsigned CELLS         = ROWS_MAX * COLS_MAX;
	localparam int unsigned CLK_PERIOD    = 12;
	localparam int unsigned RESET_CYCLES  = 12;
	// settle time covers the longest scan plus the two queued elements
	localparam int unsigned SETTLE_CYCLES = 100;
	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned RANDOM_ITEMS  = 300;
	localparam int unsigned PRINT_CAP     = 40;

	// register indexes past the two real ones, the block must ignore them
	localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = msp_pkg::CFG_IDX_W'(2);
	localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = msp_pkg::CFG_IDX_W'(3);

	// shapes of the random matrices
	typedef enum int {
		PAT_NOISE,
		PAT_SMALL_RANGE,
		PAT_FLAT,
		PAT_PLANTED,
		PAT_EXTREMES
	} grid_pattern_t;

	typedef struct {
		logic [msp_pkg::SEQ_W-1:0] seq;
		logic [msp_pkg::POS_W-1:0] row;
		logic [msp_pkg::POS_W-1:0] col;
		logic [VW-1:0]             value;
		logic                      none;
		logic                      last;
	} saddle_point_t;

	// mirror of the block: stored matrix, running row minima and column maxima
	class saddle_scoreboard;
		logic signed [VW-1:0] cells [CELLS];
		logic signed [VW-1:0] row_min [ROWS_MAX];
		logic signed [VW-1:0] col_max [COLS_MAX];
		logic [msp_pkg::CFG_W-1:0] row_reg;
		logic [msp_pkg::CFG_W-1:0] col_reg;
		int unsigned load_pos;
		saddle_point_t points_due[$];
		int unsigned failures;

		function new();
			foreach (cells[i]) cells[i] = '0;
			foreach (row_min[i]) row_min[i] = '0;
			foreach (col_max[i]) col_max[i] = '0;
			row_reg = msp_pkg::ROW_COUNT_RST;
			col_reg = msp_pkg::COL_COUNT_RST;
			load_pos = 0;
			failures = 0;
		endfunction

		// zero counts as one, anything past the maximum saturates
		function int unsigned clamp_count(logic [msp_pkg::CFG_W-1:0] n, int unsigned most);
			if (n == 0)
				return 1;
			return (n > most) ? most : int'(n);
		endfunction

		function int unsigned rows_in_use();
			return clamp_count(row_reg, ROWS_MAX);
		endfunction

		function int unsigned cols_in_use();
			return clamp_count(col_reg, COLS_MAX);
		endfunction

		function void apply_write(logic [msp_pkg::CFG_IDX_W-1:0] idx,
			logic [msp_pkg::CFG_W-1:0] data);
			case (idx)
				msp_pkg::REG_ROW_COUNT: row_reg = data;
				msp_pkg::REG_COL_COUNT: col_reg = data;
				default: return;
			endcase
			load_pos = 0;
		endfunction

		function void note_element(logic signed [VW-1:0] v);
			int unsigned rows, cols, r, c, found;
			saddle_point_t pt;
			rows = rows_in_use();
			cols = cols_in_use();
			if (load_pos >= rows * cols)
				load_pos = 0;
			r = load_pos / cols;
			c = load_pos % cols;
			cells[r * COLS_MAX + c] = v;
			if (c == 0 || v < row_min[r])
				row_min[r] = v;
			if (r == 0 || v > col_max[c])
				col_max[c] = v;
			load_pos++;
			if (load_pos < rows * cols)
				return;
			// full matrix: scan row-major, ties all count
			load_pos = 0;
			found = 0;
			for (r = 0; r < rows; r++) begin
				for (c = 0; c < cols; c++) begin
					if (cells[r * COLS_MAX + c] == row_min[r] &&
						cells[r * COLS_MAX + c] == col_max[c]) begin
						found++;
						pt.seq   = msp_pkg::SEQ_W'(found);
						pt.row   = msp_pkg::POS_W'(r);
						pt.col   = msp_pkg::POS_W'(c);
						pt.value = cells[r * COLS_MAX + c];
						pt.none  = 1'b0;
						pt.last  = 1'b0;
						points_due.push_back(pt);
					end
				end
			end
			if (found == 0) begin
				pt.seq   = '0;
				pt.row   = '0;
				pt.col   = '0;
				pt.value = '0;
				pt.none  = 1'b1;
				pt.last  = 1'b1;
				points_due.push_back(pt);
			end else begin
				points_due[points_due.size() - 1].last = 1'b1;
			end
		endfunction

		task report(string msg);
			failures++;
			if (failures <= PRINT_CAP)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_point(saddle_point_t got);
			saddle_point_t want;
			if (points_due.size() == 0) begin
				report($sformatf("result with none pending: seq %0d row %0d col %0d",
					got.seq, got.row, got.col));
				return;
			end
			want = points_due.pop_front();
			if (got.seq !== want.seq)
				report($sformatf("seq_number got %0d want %0d", got.seq, want.seq));
			if (got.row !== want.row)
				report($sformatf("point_row got %0d want %0d", got.row, want.row));
			if (got.col !== want.col)
				report($sformatf("point_col got %0d want %0d", got.col, want.col));
			if (got.value !== want.value)
				report($sformatf("point_value got %h want %h", got.value, want.value));
			if (got.none !== want.none)
				report($sformatf("none_found got %b want %b", got.none, want.none));
			if (got.last !== want.last)
				report($sformatf("last_result got %b want %b", got.last, want.last));
		endtask
	endclass

	// every input known from time zero
	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [VW-1:0]                 element_value = '0;
	logic                          wr_en = 1'b0;
	logic [msp_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [msp_pkg::CFG_W-1:0]     wr_data = '0;
	logic                          strobe;
	logic [msp_pkg::SEQ_W-1:0]     seq_number;
	logic [msp_pkg::POS_W-1:0]     point_row;
	logic [msp_pkg::POS_W-1:0]     point_col;
	logic [VW-1:0]                 point_value;
	logic                          none_found;
	logic                          last_result;

	saddle_scoreboard board;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;
	logic signed [VW-1:0] grid [CELLS];

	matrix_saddle_point_finder_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.element_value(element_value),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.strobe       (strobe),
		.seq_number   (seq_number),
		.point_row    (point_row),
		.point_col    (point_col),
		.point_value  (point_value),
		.none_found   (none_found),
		.last_result  (last_result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog: a hung block or a lost result ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// monitor: everything sampled at the edge, before this edge's updates land
	always @(posedge clk) begin
		saddle_point_t seen;
		if (arst_n) begin
			// a config write to a real register takes effect at this edge and restarts the load
			if (wr_en)
				board.apply_write(wr_index, wr_data);
			// element transfer
			if (start && !busy)
				board.note_element(element_value);
			// result transfer, one cycle only
			if (strobe) begin
				seen.seq   = seq_number;
				seen.row   = point_row;
				seen.col   = point_col;
				seen.value = point_value;
				seen.none  = none_found;
				seen.last  = last_result;
				board.check_point(seen);
			end
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// counts: mostly small, some full size, some zero or past the maximum
	function automatic logic [msp_pkg::CFG_W-1:0] pick_count();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return msp_pkg::CFG_W'($urandom_range(1, 4));
		if (roll < 80)
			return msp_pkg::CFG_W'($urandom_range(5, 8));
		if (roll < 88)
			return msp_pkg::CFG_W'(8);
		return msp_pkg::CFG_W'($urandom_range(9, 16));
	endfunction

	// start stays high when the next transfer follows at once
	task send_element(logic [VW-1:0] v);
		start <= 1'b1;
		element_value <= v;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
	endtask

	task idle_for(int unsigned n);
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold off until every pending point has come, then let the block settle
	task drain();
		start <= 1'b0;
		while (board.points_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_register(logic [msp_pkg::CFG_IDX_W-1:0] idx, logic [msp_pkg::CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task fill_grid(grid_pattern_t pattern, int unsigned rows, int unsigned cols);
		int unsigned r, c, pr, pc;
		int pivot, flat, offset;
		pr = $urandom_range(0, rows - 1);
		pc = $urandom_range(0, cols - 1);
		pivot = int'($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
		flat = int'($urandom);
		for (r = 0; r < rows; r++) begin
			for (c = 0; c < cols; c++) begin
				// ties on the planted row and column now and then
				offset = ($urandom_range(0, 3) == 0) ? 0 :
					int'($urandom_range(1, 32'h4000_0000));
				case (pattern)
					PAT_SMALL_RANGE: grid[r * cols + c] = int'($urandom_range(0, 6)) - 3;
					PAT_FLAT: grid[r * cols + c] = flat;
					PAT_EXTREMES:
						case ($urandom_range(0, 3))
							0: grid[r * cols + c] = 32'sh8000_0000;
							1: grid[r * cols + c] = 32'sh7fff_ffff;
							2: grid[r * cols + c] = '0;
							default: grid[r * cols + c] = '1;
						endcase
					PAT_PLANTED:
						// pivot is the row minimum and the column maximum
						if (r == pr && c == pc)
							grid[r * cols + c] = pivot;
						else if (r == pr)
							grid[r * cols + c] = pivot + offset;
						else if (c == pc)
							grid[r * cols + c] = pivot - offset;
						else
							grid[r * cols + c] = $urandom;
					default: grid[r * cols + c] = $urandom;
				endcase
			end
		end
	endtask

	task send_grid(int unsigned count, bit no_gaps);
		int unsigned i;
		for (i = 0; i < count; i++) begin
			send_element(grid[i]);
			if (!no_gaps)
				idle_for(pick_gap());
		end
	endtask

	task pick_pattern(output grid_pattern_t pattern);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			pattern = PAT_NOISE;
		else if (roll < 45)
			pattern = PAT_SMALL_RANGE;
		else if (roll < 55)
			pattern = PAT_FLAT;
		else if (roll < 90)
			pattern = PAT_PLANTED;
		else
			pattern = PAT_EXTREMES;
	endtask

	initial begin
		int unsigned random_goal, rows, cols, total;
		bit retune;
		grid_pattern_t pattern;

		board = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// partial load at the reset size, thrown away by the config write
		send_element(32'h7fff_ffff);
		send_element(32'h8000_0000);
		drain();

		// 1x1: every element is its own saddle point
		set_register(msp_pkg::REG_ROW_COUNT, 4'd1);
		set_register(msp_pkg::REG_COL_COUNT, 4'd1);
		send_element(32'h8000_0000);
		send_element(32'h7fff_ffff);
		idle_for(3);
		send_element(32'hffff_ffff);
		drain();

		// zero counts behave as one
		set_register(msp_pkg::REG_ROW_COUNT, 4'd0);
		set_register(msp_pkg::REG_COL_COUNT, 4'd0);
		send_element(32'h0000_0000);
		drain();

		// 15 rows saturate to 8, one column; tie at the column maximum
		set_register(msp_pkg::REG_ROW_COUNT, 4'hf);
		set_register(msp_pkg::REG_COL_COUNT, 4'd1);
		send_element(32'h0000_0005);
		send_element(32'h8000_0000);
		send_element(32'h7fff_ffff);
		send_element(32'hffff_fff9);
		drain();
		// writes past the register list must not restart the load
		set_register(REG_SPARE_HI, 4'hf);
		set_register(REG_SPARE_LO, 4'h0);
		send_element(32'h7fff_ffff);
		send_element(32'h0000_0000);
		send_element(32'h0000_0001);
		send_element(32'hffff_ffff);
		drain();

		// one row, 9 columns saturate to 8, all equal: eight points
		set_register(msp_pkg::REG_ROW_COUNT, 4'd1);
		set_register(msp_pkg::REG_COL_COUNT, 4'd9);
		repeat (8) send_element(32'hffff_ffff);
		drain();

		// 2x2 with no saddle point
		set_register(msp_pkg::REG_ROW_COUNT, 4'd2);
		set_register(msp_pkg::REG_COL_COUNT, 4'd2);
		send_element(32'd1);
		send_element(32'd2);
		send_element(32'd2);
		send_element(32'd1);

		// random matrices, mostly shaped to hold saddle points
		random_goal = items_sent + RANDOM_ITEMS;
		retune = 1'b1;
		while (items_sent < random_goal) begin
			if (retune || $urandom_range(0, 3) == 0) begin
				drain();
				case ($urandom_range(0, 3))
					0: set_register(msp_pkg::REG_ROW_COUNT, pick_count());
					1: set_register(msp_pkg::REG_COL_COUNT, pick_count());
					default: begin
						set_register(msp_pkg::REG_ROW_COUNT, pick_count());
						set_register(msp_pkg::REG_COL_COUNT, pick_count());
					end
				endcase
				if ($urandom_range(0, 5) == 0)
					set_register($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
						msp_pkg::CFG_W'($urandom));
				retune = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				// sender holds off until the last point is out
				drain();
			end
			rows = board.rows_in_use();
			cols = board.cols_in_use();
			total = rows * cols;
			pick_pattern(pattern);
			fill_grid(pattern, rows, cols);
			if (total > 1 && $urandom_range(0, 9) == 0) begin
				// broken matrix: cut short, then restarted by a config write
				send_grid($urandom_range(1, total - 1), 1'b0);
				retune = 1'b1;
			end else begin
				send_grid(total, $urandom_range(0, 3) == 0);
			end
		end

		drain();
		if (board.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
